// ----- sv/tetra_plane_cut_filter_unit_macros.svh -----
// Assertion macros for the tetrahedron plane-cut filter.
// Define ASSERT_OFF to compile every check away.
`ifndef TETRA_PLANE_CUT_FILTER_UNIT_MACROS_SVH
`define TETRA_PLANE_CUT_FILTER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted.
`define TPCF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define TPCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TPCF_ASSERT(lbl, clk, rst_n, prop, msg)
`define TPCF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/tpcf_pkg.sv -----
// Shared types and constants of the tetrahedron plane-cut filter.
// Used by tpcf_vstore, tpcf_mac and tetra_plane_cut_filter_unit.
package tpcf_pkg;

    localparam int COORD_BITS    = 32;
    localparam int EDGE_BITS     = COORD_BITS + 1;
    localparam int VADDR_BITS    = 16;
    localparam int VERTEX_DEPTH  = 2 ** VADDR_BITS;
    localparam int VCOUNT_BITS   = VADDR_BITS + 1;
    localparam int VERTEX_BITS   = 3 * COORD_BITS;
    localparam int TET_BITS      = 24;
    localparam int TOL_BITS      = 63;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 63'd281474977;

    // multiplier and accumulator widths
    localparam int MINOR_LO_BITS = EDGE_BITS + 1;
    localparam int OPA_BITS      = MINOR_LO_BITS + 1;
    localparam int PROD_BITS     = OPA_BITS + EDGE_BITS;
    localparam int MINOR_BITS    = 2 * EDGE_BITS + 1;
    localparam int DET_BITS      = 104;
    localparam int CHECK_BITS    = 64;

    // stream and configuration widths
    localparam int S_DATA_BITS   = 200;
    localparam int S_USER_BITS   = 2;
    localparam int M_DATA_BITS   = 2 * TET_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = TOL_BITS;
    localparam int AXIS_BITS     = 2;

    localparam logic [AXIS_BITS-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_BITS-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_BITS-1:0] AXIS_Z = 2'd2;

    // steps of one determinant term
    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] PH_MIN0 = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_MIN1 = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_WAIT = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_LO   = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_HI   = 3'd4;
    localparam logic [1:0] TERM_LAST = 2'd2;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_TEST  = 2'd1,
        CMD_PASS  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_AXIS   = 2'd0,
        REG_PLANE  = 2'd1,
        REG_VCOUNT = 2'd2,
        REG_TOL    = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_DRAIN,
        ST_ABS,
        ST_CHECK,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        SRC_EDGE     = 2'd0,
        SRC_MINOR_LO = 2'd1,
        SRC_MINOR_HI = 2'd2
    } t_src;

    typedef struct packed {
        logic en;
        t_src a_src;
        logic dest_det;
        logic sub;
        logic load;
    } t_mac_ctl;

endpackage

// ----- sv/tpcf_vstore.sv -----
// Vertex store: one write port, one registered read port, x/y/z per word.
// Depends on tpcf_pkg.
module tpcf_vstore import tpcf_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [VADDR_BITS-1:0]  i_waddr,
    input  logic [VERTEX_BITS-1:0] i_wdata,   // x, y, z from bit 0 up
    input  logic                   i_re,
    input  logic [VADDR_BITS-1:0]  i_raddr,
    output logic [VERTEX_BITS-1:0] o_rdata
);

    logic [VERTEX_BITS-1:0] mem [VERTEX_DEPTH];
    logic [VERTEX_BITS-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/tpcf_mac.sv -----
// Shared multiply-accumulate unit for the 3x3 determinant: registered product,
// then a minor accumulator and a full-width determinant accumulator. Uses tpcf_pkg.
`include "tetra_plane_cut_filter_unit_macros.svh"
module tpcf_mac import tpcf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic signed [EDGE_BITS-1:0] i_edge_a,
    input  logic signed [EDGE_BITS-1:0] i_edge_b,
    output logic signed [DET_BITS-1:0]  o_det
);

    t_mac_ctl                     r_ctl1;
    logic signed [PROD_BITS-1:0]  r_prod;
    logic signed [MINOR_BITS-1:0] r_minor;
    logic signed [DET_BITS-1:0]   r_det;

    logic signed [OPA_BITS-1:0]   w_op_a;
    logic signed [MINOR_BITS-1:0] w_p_minor;
    logic signed [MINOR_BITS-1:0] w_t_minor;
    logic signed [DET_BITS-1:0]   w_p_det;
    logic signed [DET_BITS-1:0]   w_t_det;
    logic signed [MINOR_BITS-1:0] n_minor;
    logic signed [DET_BITS-1:0]   n_det;

    // The minor is split: unsigned low part and signed high part, weight 2^MINOR_LO_BITS.
    always_comb begin
        unique case (i_ctl.a_src)
            SRC_EDGE:     w_op_a = OPA_BITS'(i_edge_a);
            SRC_MINOR_LO: w_op_a = {1'b0, r_minor[MINOR_LO_BITS-1:0]};
            SRC_MINOR_HI: w_op_a = OPA_BITS'($signed(r_minor[MINOR_BITS-1:MINOR_LO_BITS]));
            default:      w_op_a = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
        end else begin
            r_ctl1 <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_op_a * i_edge_b;
    end

    always_comb begin
        w_p_minor = r_prod[MINOR_BITS-1:0];
        w_t_minor = r_ctl1.sub ? -w_p_minor : w_p_minor;
        n_minor   = r_ctl1.load ? w_t_minor : r_minor + w_t_minor;

        w_p_det = DET_BITS'(r_prod);
        if (r_ctl1.a_src == SRC_MINOR_HI) begin
            w_p_det = w_p_det <<< MINOR_LO_BITS;
        end
        w_t_det = r_ctl1.sub ? -w_p_det : w_p_det;
        n_det   = r_ctl1.load ? w_t_det : r_det + w_t_det;
    end

    always_ff @(posedge i_clk) begin
        if (r_ctl1.en && !r_ctl1.dest_det) begin
            r_minor <= n_minor;
        end
        if (r_ctl1.en && r_ctl1.dest_det) begin
            r_det <= n_det;
        end
    end

    assign o_det = r_det;

    `TPCF_ASSERT(a_minor_ready, i_clk, i_rst_n, (i_ctl.en && i_ctl.a_src != SRC_EDGE) |-> !(r_ctl1.en && !r_ctl1.dest_det), "minor read while still accumulating")
    `TPCF_ASSERT(a_det_from_minor, i_clk, i_rst_n, (i_ctl.en && i_ctl.dest_det) |-> (i_ctl.a_src == SRC_MINOR_LO || i_ctl.a_src == SRC_MINOR_HI), "determinant fed from a raw edge product")
    `TPCF_ASSERT(a_minor_from_edge, i_clk, i_rst_n, (i_ctl.en && !i_ctl.dest_det) |-> (i_ctl.a_src == SRC_EDGE), "minor fed from the minor itself")

endmodule

// ----- sv/tetra_plane_cut_filter_unit.sv -----
// Top level of the tetrahedron plane-cut filter: stream ports, config registers,
// sequencer. Instantiates tpcf_vstore and tpcf_mac; uses tpcf_pkg.
//
// Vertex writes (tuser 0) and new-pass beats (tuser 2) may follow back to back.
// A test beat (tuser 1) with any corner at or above vertex_count is dropped in
// its accept cycle. A valid test holds tready low from its accept until it is
// through, and longer while the output register waits for tready: four reads
// from the single store read port, fifteen steps of the one shared 35x33
// multiplier (two products per 2x2 minor and two per minor times edge, a settle
// step per minor), then drain, absolute value, and tolerance and plane check.
// Results go through an output register, so a new beat is accepted while a kept
// result still waits on the output side. A cut axis of 3 keeps nothing. The
// vertex store has no reset; a test must only name vertices already written.
`include "tetra_plane_cut_filter_unit_macros.svh"
module tetra_plane_cut_filter_unit import tpcf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // input stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // vertex_addr[15:0], coord_x[47:16], coord_y[79:48], coord_z[111:80],
    // corner_a[127:112], corner_b[143:128], corner_c[159:144],
    // corner_d[175:160], tet_number[199:176]
    input  logic [S_DATA_BITS-1:0]   i_s_axis_tdata,
    input  logic [S_USER_BITS-1:0]   i_s_axis_tuser,   // cmd[1:0]
    // result stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [M_DATA_BITS-1:0]   o_m_axis_tdata,   // kept_tet[23:0], kept_position[47:24]
    // configuration writes
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    // config registers
    logic [AXIS_BITS-1:0]          r_axis;
    logic signed [COORD_BITS-1:0]  r_plane;
    logic [VCOUNT_BITS-1:0]        r_vcount;
    logic [TOL_BITS-1:0]           r_tol;

    t_state                        r_state, n_state;
    logic [2:0]                    r_rd_cnt;
    logic [1:0]                    r_term;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [VADDR_BITS-1:0]         r_corner [4];
    logic [TET_BITS-1:0]           r_tet;
    logic [TET_BITS-1:0]           r_kept_count;
    logic [VERTEX_BITS-1:0]        r_va;
    logic signed [EDGE_BITS-1:0]   r_ex [3];
    logic signed [EDGE_BITS-1:0]   r_ey [3];
    logic signed [EDGE_BITS-1:0]   r_ez [3];
    logic                          r_low, r_high;
    logic [DET_BITS-1:0]           r_abs;

    logic                          r_out_valid;
    logic [TET_BITS-1:0]           r_out_tet;
    logic [TET_BITS-1:0]           r_out_pos;

    logic                          w_s_accept;
    t_cmd                          w_cmd;
    logic                          w_bad_corner;
    logic                          w_out_free;
    logic                          w_rd_en;
    logic [VERTEX_BITS-1:0]        w_rdata;
    logic signed [COORD_BITS-1:0]  w_rd_x, w_rd_y, w_rd_z, w_rd_axis;
    logic signed [COORD_BITS-1:0]  w_va_x, w_va_y, w_va_z;
    logic                          w_le, w_ge;
    t_mac_ctl                      w_ctl;
    logic signed [EDGE_BITS-1:0]   w_op_a, w_op_b;
    logic signed [EDGE_BITS-1:0]   w_m1a, w_m1b, w_m2a, w_m2b, w_e;
    logic                          w_neg;
    logic signed [DET_BITS-1:0]    w_det;
    logic                          w_below;
    logic                          w_keep;

    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;
    assign w_cmd           = t_cmd'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;

    assign w_bad_corner = ({1'b0, i_s_axis_tdata[127:112]} >= r_vcount) ||
                          ({1'b0, i_s_axis_tdata[143:128]} >= r_vcount) ||
                          ({1'b0, i_s_axis_tdata[159:144]} >= r_vcount) ||
                          ({1'b0, i_s_axis_tdata[175:160]} >= r_vcount);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis   <= AXIS_X;
            r_plane  <= '0;
            r_vcount <= '0;
            r_tol    <= TOL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_AXIS:   r_axis   <= i_cfg_data[AXIS_BITS-1:0];
                REG_PLANE:  r_plane  <= i_cfg_data[COORD_BITS-1:0];
                REG_VCOUNT: r_vcount <= i_cfg_data[VCOUNT_BITS-1:0];
                REG_TOL:    r_tol    <= i_cfg_data[TOL_BITS-1:0];
                default:    ;
            endcase
        end
    end

    // vertex store
    assign w_rd_en = (r_state == ST_READ) && !r_rd_cnt[2];

    tpcf_vstore u_vstore (
        .i_clk   (i_clk),
        .i_we    (w_s_accept && w_cmd == CMD_WRITE),
        .i_waddr (i_s_axis_tdata[VADDR_BITS-1:0]),
        .i_wdata (i_s_axis_tdata[111:16]),
        .i_re    (w_rd_en),
        .i_raddr (r_corner[r_rd_cnt[1:0]]),
        .o_rdata (w_rdata)
    );

    assign w_rd_x = w_rdata[COORD_BITS-1:0];
    assign w_rd_y = w_rdata[2*COORD_BITS-1:COORD_BITS];
    assign w_rd_z = w_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign w_va_x = r_va[COORD_BITS-1:0];
    assign w_va_y = r_va[2*COORD_BITS-1:COORD_BITS];
    assign w_va_z = r_va[3*COORD_BITS-1:2*COORD_BITS];

    always_comb begin
        unique case (r_axis)
            AXIS_X:  w_rd_axis = w_rd_x;
            AXIS_Y:  w_rd_axis = w_rd_y;
            default: w_rd_axis = w_rd_z;
        endcase
        w_le = (w_rd_axis <= r_plane);
        w_ge = (w_rd_axis >= r_plane);
    end

    // operands of the current determinant term
    always_comb begin
        unique case (r_term)
            2'd0: begin
                w_m1a = r_ey[1]; w_m1b = r_ez[2]; w_m2a = r_ez[1]; w_m2b = r_ey[2];
                w_e   = r_ex[0]; w_neg = 1'b0;
            end
            2'd1: begin
                w_m1a = r_ex[1]; w_m1b = r_ez[2]; w_m2a = r_ez[1]; w_m2b = r_ex[2];
                w_e   = r_ey[0]; w_neg = 1'b1;
            end
            default: begin
                w_m1a = r_ex[1]; w_m1b = r_ey[2]; w_m2a = r_ey[1]; w_m2b = r_ex[2];
                w_e   = r_ez[0]; w_neg = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_ctl  = '0;
        w_op_a = w_e;
        w_op_b = w_e;
        if (r_state == ST_MAC) begin
            unique case (r_phase)
                PH_MIN0: begin
                    w_ctl  = '{en: 1'b1, a_src: SRC_EDGE, dest_det: 1'b0, sub: 1'b0,
                              load: 1'b1};
                    w_op_a = w_m1a;
                    w_op_b = w_m1b;
                end
                PH_MIN1: begin
                    w_ctl  = '{en: 1'b1, a_src: SRC_EDGE, dest_det: 1'b0, sub: 1'b1,
                              load: 1'b0};
                    w_op_a = w_m2a;
                    w_op_b = w_m2b;
                end
                PH_LO: begin
                    w_ctl = '{en: 1'b1, a_src: SRC_MINOR_LO, dest_det: 1'b1, sub: w_neg,
                             load: (r_term == 2'd0)};
                end
                PH_HI: begin
                    w_ctl = '{en: 1'b1, a_src: SRC_MINOR_HI, dest_det: 1'b1, sub: w_neg,
                             load: 1'b0};
                end
                default: ;
            endcase
        end
    end

    tpcf_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_edge_a (w_op_a),
        .i_edge_b (w_op_b),
        .o_det    (w_det)
    );

    assign w_below = (r_abs[DET_BITS-1:CHECK_BITS] == '0) &&
                     (r_abs[CHECK_BITS-1:0] < {1'b0, r_tol});

    // keep only a sound tetrahedron that straddles the plane on a real axis
    assign w_keep = !w_below && r_low && r_high &&
                    (r_axis == AXIS_X || r_axis == AXIS_Y || r_axis == AXIS_Z);

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_accept && w_cmd == CMD_TEST && !w_bad_corner) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_rd_cnt == 3'd4) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                if (r_term == TERM_LAST && r_phase == PH_HI) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_ABS;
            ST_ABS:   n_state = ST_CHECK;
            ST_CHECK: n_state = w_keep ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_cnt <= '0;
            r_term   <= '0;
            r_phase  <= PH_MIN0;
        end else begin
            if (r_state == ST_READ) begin
                r_rd_cnt <= r_rd_cnt + 3'd1;
            end else begin
                r_rd_cnt <= '0;
            end
            if (r_state == ST_MAC) begin
                if (r_phase == PH_HI) begin
                    r_phase <= PH_MIN0;
                    r_term  <= (r_term == TERM_LAST) ? 2'd0 : r_term + 2'd1;
                end else begin
                    r_phase <= r_phase + 3'd1;
                end
            end else begin
                r_phase <= PH_MIN0;
                r_term  <= '0;
            end
        end
    end

    // capture the test beat, then gather corners as they come out of the store
    always_ff @(posedge i_clk) begin
        if (w_s_accept && w_cmd == CMD_TEST) begin
            r_corner[0] <= i_s_axis_tdata[127:112];
            r_corner[1] <= i_s_axis_tdata[143:128];
            r_corner[2] <= i_s_axis_tdata[159:144];
            r_corner[3] <= i_s_axis_tdata[175:160];
            r_tet       <= i_s_axis_tdata[199:176];
        end
        if (r_state == ST_READ && r_rd_cnt != 3'd0) begin
            if (r_rd_cnt == 3'd1) begin
                r_va   <= w_rdata;
                r_low  <= w_le;
                r_high <= w_ge;
            end else begin
                r_low  <= r_low || w_le;
                r_high <= r_high || w_ge;
            end
            for (int k = 0; k < 3; k++) begin
                if (r_rd_cnt == 3'(k + 2)) begin
                    r_ex[k] <= EDGE_BITS'(w_rd_x) - EDGE_BITS'(w_va_x);
                    r_ey[k] <= EDGE_BITS'(w_rd_y) - EDGE_BITS'(w_va_y);
                    r_ez[k] <= EDGE_BITS'(w_rd_z) - EDGE_BITS'(w_va_z);
                end
            end
        end
        if (r_state == ST_ABS) begin
            r_abs <= w_det[DET_BITS-1] ? DET_BITS'(-w_det) : DET_BITS'(w_det);
        end
    end

    // output register and kept count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_kept_count <= '0;
        end else begin
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid  <= 1'b1;
                r_kept_count <= r_kept_count + TET_BITS'(1);
            end else begin
                if (i_m_axis_tready) begin
                    r_out_valid <= 1'b0;
                end
                if (w_s_accept && w_cmd == CMD_PASS) begin
                    r_kept_count <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_tet <= r_tet;
            r_out_pos <= r_kept_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_pos, r_out_tet};

    `TPCF_ASSERT(a_busy_no_accept, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !o_s_axis_tready, "beat accepted during a test")
    `TPCF_ASSERT(a_emit_count, i_clk, i_rst_n, (r_state == ST_EMIT && w_out_free) |=> (r_out_valid && TET_BITS'(r_out_pos + TET_BITS'(1)) == r_kept_count), "kept position and kept count out of step")
    `TPCF_ASSERT(a_test_starts, i_clk, i_rst_n, (w_s_accept && w_cmd == CMD_TEST && !w_bad_corner) |=> (r_state == ST_READ && r_rd_cnt == 3'd0), "valid test did not start reading corners")

endmodule
